/* design/bcq_pkg.sv */
// Shared types and constants for the box collider query unit.
package bcq_pkg;

  localparam int COORD_W  = 32;
  localparam int DIM_W    = 31;
  localparam int FUNC_W   = 2;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int CORNER_W = 33;
  localparam int DBL_W    = 35;
  localparam int MAG_W    = 34;
  localparam int DEN_W    = 33;
  localparam int OFF_W    = 33;
  localparam int SQ_W     = 62;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  localparam logic [FUNC_W-1:0] FUNC_BOX    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CIRCLE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RAY    = 2'd2;

  localparam logic [1:0] REG_POS_X  = 2'd0;
  localparam logic [1:0] REG_POS_Y  = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  localparam logic [DIM_W-1:0] DIST_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] extent_x;
    logic signed [COORD_W-1:0] extent_y;
    logic [DIM_W-1:0]          radius;
  } query_t;

  typedef struct packed {
    logic             hit;
    logic [DIM_W-1:0] hit_distance;
  } result_t;

  // Box edges derived from the configuration registers.
  typedef struct packed {
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic signed [CORNER_W-1:0] br_x;
    logic signed [CORNER_W-1:0] br_y;
    logic signed [DBL_W-1:0]    lo2_x;
    logic signed [DBL_W-1:0]    hi2_x;
    logic signed [DBL_W-1:0]    lo2_y;
    logic signed [DBL_W-1:0]    hi2_y;
  } box_geom_t;

  // Classified query as handed from the front end to the back end.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              hit_box;
    logic              circ_ok;
    logic [SQ_W-1:0]   sq_dx;
    logic [SQ_W-1:0]   sq_dy;
    logic [SQ_W-1:0]   sq_r;
    logic              miss_static;
    logic              zero_x;
    logic              zero_y;
    logic [MAG_W-1:0]  mag_lo_x;
    logic [MAG_W-1:0]  mag_hi_x;
    logic [MAG_W-1:0]  mag_lo_y;
    logic [MAG_W-1:0]  mag_hi_y;
    logic [3:0]        neg;
    logic [DEN_W-1:0]  den_x;
    logic [DEN_W-1:0]  den_y;
  } front_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

/* design/bcq_front.sv */
// Front end: accept queries, run the box and circle tests, set up the slab divisions.
module bcq_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 query_valid,
  output logic                 query_stall,
  input  bcq_pkg::query_t      query,
  input  bcq_pkg::box_geom_t   geom,
  input  logic                 fifo_full,
  output logic                 push,
  output bcq_pkg::front_item_t item
);
  import bcq_pkg::*;

  function automatic logic overlap_axis(input logic signed [COORD_W-1:0] p,
                                        input logic signed [COORD_W-1:0] e,
                                        input logic signed [COORD_W-1:0] lo,
                                        input logic signed [CORNER_W-1:0] hi);
    logic signed [CORNER_W:0] pw, ow, lw, hw;
    begin
      pw = {p[COORD_W-1], p[COORD_W-1], p};
      ow = pw + {e[COORD_W-1], e[COORD_W-1], e};
      lw = {lo[COORD_W-1], lo[COORD_W-1], lo};
      hw = {hi[CORNER_W-1], hi};
      overlap_axis = !((hw <= pw) || (lw >= ow));
    end
  endfunction

  function automatic logic [OFF_W-1:0] clamp_off(input logic signed [COORD_W-1:0] p,
                                                 input logic signed [COORD_W-1:0] lo,
                                                 input logic signed [CORNER_W-1:0] hi);
    logic signed [CORNER_W:0] pw, lw, hw, db, da;
    begin
      pw = {p[COORD_W-1], p[COORD_W-1], p};
      lw = {lo[COORD_W-1], lo[COORD_W-1], lo};
      hw = {hi[CORNER_W-1], hi};
      db = lw - pw;
      da = pw - hw;
      if (pw < lw) begin
        clamp_off = db[OFF_W-1:0];
      end else if (pw > hw) begin
        clamp_off = da[OFF_W-1:0];
      end else begin
        clamp_off = '0;
      end
    end
  endfunction

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [DBL_W-1:0] d);
    logic [DBL_W-1:0] n;
    begin
      n = d[DBL_W-1] ? (~d + DBL_W'(1)) : d;
      mag_of = n[MAG_W-1:0];
    end
  endfunction

  function automatic logic [DEN_W-1:0] den_of(input logic signed [COORD_W-1:0] e);
    logic [COORD_W-1:0] n;
    begin
      n = e[COORD_W-1] ? (~e + COORD_W'(1)) : e;
      den_of = {n, 1'b0};
    end
  endfunction

  logic adv;

  // Stage 1: accepted query.
  logic   v1;
  query_t q1;

  // Stage 2: offsets and slab differences.
  logic                      v2;
  logic [FUNC_W-1:0]         func2;
  logic                      hit_box2;
  logic [OFF_W-1:0]          dx2, dy2;
  logic [DIM_W-1:0]          r2;
  logic signed [COORD_W-1:0] ex2, ey2;
  logic signed [DBL_W-1:0]   dlo_x2, dhi_x2, dlo_y2, dhi_y2;

  logic                      v3;

  logic signed [DBL_W-1:0] o2_x, o2_y;
  logic                    zx, zy, inr_x, inr_y;

  assign adv         = !(v3 && fifo_full);
  assign query_stall = !adv;
  assign push        = v3 && !fifo_full;

  assign o2_x  = {q1.point_x[COORD_W-1], q1.point_x[COORD_W-1], q1.point_x, 1'b0};
  assign o2_y  = {q1.point_y[COORD_W-1], q1.point_y[COORD_W-1], q1.point_y, 1'b0};
  assign zx    = (ex2 == '0);
  assign zy    = (ey2 == '0);
  assign inr_x = (dlo_x2[DBL_W-1] || (dlo_x2 == '0)) && !dhi_x2[DBL_W-1];
  assign inr_y = (dlo_y2[DBL_W-1] || (dlo_y2 == '0)) && !dhi_y2[DBL_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= query_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q1 <= query;

      func2    <= q1.func;
      hit_box2 <= overlap_axis(q1.point_x, q1.extent_x, geom.pos_x, geom.br_x)
               && overlap_axis(q1.point_y, q1.extent_y, geom.pos_y, geom.br_y);
      dx2      <= clamp_off(q1.point_x, geom.pos_x, geom.br_x);
      dy2      <= clamp_off(q1.point_y, geom.pos_y, geom.br_y);
      r2       <= q1.radius;
      ex2      <= q1.extent_x;
      ey2      <= q1.extent_y;
      dlo_x2   <= geom.lo2_x - o2_x;
      dhi_x2   <= geom.hi2_x - o2_x;
      dlo_y2   <= geom.lo2_y - o2_y;
      dhi_y2   <= geom.hi2_y - o2_y;

      item.func        <= func2;
      item.hit_box     <= hit_box2;
      item.circ_ok     <= (dx2 <= OFF_W'(r2)) && (dy2 <= OFF_W'(r2));
      item.sq_dx       <= dx2[DIM_W-1:0] * dx2[DIM_W-1:0];
      item.sq_dy       <= dy2[DIM_W-1:0] * dy2[DIM_W-1:0];
      item.sq_r        <= r2 * r2;
      item.miss_static <= (zx && zy) || (zx && !inr_x) || (zy && !inr_y);
      item.zero_x      <= zx;
      item.zero_y      <= zy;
      item.mag_lo_x    <= mag_of(dlo_x2);
      item.mag_hi_x    <= mag_of(dhi_x2);
      item.mag_lo_y    <= mag_of(dlo_y2);
      item.mag_hi_y    <= mag_of(dhi_y2);
      item.neg         <= {dhi_y2[DBL_W-1] ^ ey2[COORD_W-1],
                           dlo_y2[DBL_W-1] ^ ey2[COORD_W-1],
                           dhi_x2[DBL_W-1] ^ ex2[COORD_W-1],
                           dlo_x2[DBL_W-1] ^ ex2[COORD_W-1]};
      item.den_x       <= den_of(ex2);
      item.den_y       <= den_of(ey2);
    end
  end

endmodule

/* design/bcq_fifo.sv */
// Short queue between the front end and the back end.
module bcq_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  bcq_pkg::front_item_t  din,
  input  logic                  pop,
  output bcq_pkg::front_item_t  dout,
  output bcq_pkg::fifo_status_t status
);
  import bcq_pkg::*;

  front_item_t           slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CNT_W-1:0] count;

  assign status.full  = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign status.empty = (count == '0);
  assign dout         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + FIFO_CNT_W'(1);
        2'b01:   count <= count - FIFO_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* design/bcq_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module bcq_div #(
  parameter int N_W = 50,
  parameter int D_W = 33
) (
  input  logic           clk,
  input  logic           en,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic [N_W-1:0] quo,
  output logic           rem_nz
);

  logic [D_W-1:0] rem_q [N_W];
  logic [N_W-1:0] nq_q  [N_W];
  logic [D_W-1:0] den_q [N_W-1];

  for (genvar s = 0; s < N_W; s++) begin : g_stage
    logic [D_W-1:0] rem_in, den_in;
    logic [N_W-1:0] nq_in;
    logic [D_W:0]   trial, diff;
    logic           ge;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign nq_in  = nq_q[s-1];
      assign den_in = den_q[s-1];
    end

    assign trial = {rem_in, nq_in[N_W-1]};
    assign ge    = (trial >= {1'b0, den_in});
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
        nq_q[s]  <= {nq_in[N_W-2:0], ge};
      end
    end

    if (s < N_W - 1) begin : g_den
      always_ff @(posedge clk) begin
        if (en) begin
          den_q[s] <= den_in;
        end
      end
    end
  end

  assign quo    = nq_q[N_W-1];
  assign rem_nz = |rem_q[N_W-1];

endmodule

/* design/bcq_back.sv */
// Back end: finish the circle test, divide the slabs, combine and register the result.
module bcq_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bcq_pkg::front_item_t fifo_item,
  input  logic                 fifo_empty,
  output logic                 pop,
  input  logic                 result_stall,
  output logic                 result_valid,
  output bcq_pkg::result_t     result
);
  import bcq_pkg::*;

  localparam int NW = MAG_W + FRAC_BITS;
  localparam int TW = NW + 2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              hit_pre;
    logic              miss_static;
    logic              zero_x;
    logic              zero_y;
    logic [3:0]        neg;
  } side_t;

  localparam logic signed [TW-1:0] T_INF = TW'(1) << NW;

  logic be;
  side_t side_in;
  logic [SQ_W:0] d2;

  logic [NW-1:0] div_num [4];
  logic [NW-1:0] div_quo [4];
  logic [3:0]    div_nz;

  side_t side_q [NW];
  logic  v_q    [NW];

  logic signed [TW-1:0] t1_q [4];
  side_t                side1_q;
  logic                 v1_q;

  logic signed [TW-1:0] xl_q, xh_q, yl_q, yh_q;
  side_t                side2_q;
  logic                 v2_q;

  logic signed [TW-1:0] tmin_q, tmax_q;
  side_t                side3_q;
  logic                 v3_q;

  logic signed [TW-1:0] entry;
  logic                 ray_hit;
  logic [DIM_W-1:0]     ray_dist;
  result_t              res_c;

  assign be  = !(result_valid && result_stall);
  assign pop = be && !fifo_empty;

  assign d2 = {1'b0, fifo_item.sq_dx} + {1'b0, fifo_item.sq_dy};

  always_comb begin
    side_in.func        = fifo_item.func;
    side_in.hit_pre     = (fifo_item.func == FUNC_BOX) ? fifo_item.hit_box
                        : (fifo_item.circ_ok && (d2 <= {1'b0, fifo_item.sq_r}));
    side_in.miss_static = fifo_item.miss_static;
    side_in.zero_x      = fifo_item.zero_x;
    side_in.zero_y      = fifo_item.zero_y;
    side_in.neg         = fifo_item.neg;
  end

  assign div_num[0] = NW'(fifo_item.mag_lo_x) << FRAC_BITS;
  assign div_num[1] = NW'(fifo_item.mag_hi_x) << FRAC_BITS;
  assign div_num[2] = NW'(fifo_item.mag_lo_y) << FRAC_BITS;
  assign div_num[3] = NW'(fifo_item.mag_hi_y) << FRAC_BITS;

  for (genvar l = 0; l < 4; l++) begin : g_lane
    bcq_div #(.N_W(NW), .D_W(DEN_W)) u_div (
      .clk    (clk),
      .en     (be),
      .num    (div_num[l]),
      .den    ((l < 2) ? fifo_item.den_x : fifo_item.den_y),
      .quo    (div_quo[l]),
      .rem_nz (div_nz[l])
    );
  end

  for (genvar s = 0; s < NW; s++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[s] <= 1'b0;
      end else if (be) begin
        v_q[s] <= (s == 0) ? !fifo_empty : v_q[(s == 0) ? 0 : s-1];
      end
    end
    always_ff @(posedge clk) begin
      if (be) begin
        side_q[s] <= (s == 0) ? side_in : side_q[(s == 0) ? 0 : s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      v3_q         <= 1'b0;
      result_valid <= 1'b0;
    end else if (be) begin
      v1_q         <= v_q[NW-1];
      v2_q         <= v1_q;
      v3_q         <= v2_q;
      result_valid <= v3_q;
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      // Apply the quotient sign with floor rounding.
      for (int l = 0; l < 4; l++) begin
        if (side_q[NW-1].neg[l]) begin
          t1_q[l] <= div_nz[l] ? ~TW'(div_quo[l]) : (~TW'(div_quo[l]) + TW'(1));
        end else begin
          t1_q[l] <= TW'(div_quo[l]);
        end
      end
      side1_q <= side_q[NW-1];

      xl_q    <= side1_q.zero_x ? -T_INF : ((t1_q[0] < t1_q[1]) ? t1_q[0] : t1_q[1]);
      xh_q    <= side1_q.zero_x ?  T_INF : ((t1_q[0] < t1_q[1]) ? t1_q[1] : t1_q[0]);
      yl_q    <= side1_q.zero_y ? -T_INF : ((t1_q[2] < t1_q[3]) ? t1_q[2] : t1_q[3]);
      yh_q    <= side1_q.zero_y ?  T_INF : ((t1_q[2] < t1_q[3]) ? t1_q[3] : t1_q[2]);
      side2_q <= side1_q;

      tmin_q  <= (xl_q > yl_q) ? xl_q : yl_q;
      tmax_q  <= (xh_q < yh_q) ? xh_q : yh_q;
      side3_q <= side2_q;

      result  <= res_c;
    end
  end

  assign entry    = tmin_q[TW-1] ? '0 : tmin_q;
  assign ray_hit  = !side3_q.miss_static && (tmax_q >= entry);
  assign ray_dist = (entry > $signed(TW'(DIST_MAX))) ? DIST_MAX : entry[DIM_W-1:0];

  always_comb begin
    res_c.hit_distance = '0;
    unique case (side3_q.func)
      FUNC_BOX:    res_c.hit = side3_q.hit_pre;
      FUNC_CIRCLE: res_c.hit = side3_q.hit_pre;
      FUNC_RAY: begin
        res_c.hit          = ray_hit;
        res_c.hit_distance = ray_hit ? ray_dist : '0;
      end
      default:     res_c.hit = 1'b0;
    endcase
  end

endmodule

/* design/box_collider_queries_unit.sv */
// Box collider query unit: top level with configuration registers and block wiring.
//
// Answers box-overlap, circle-overlap and ray-cast queries against one
// axis-aligned box held in four APB registers (x, y, width, height at byte
// addresses 0, 4, 8, 12; Q16.16 by default). Every query produces exactly one
// result. The unit takes one query per clock and holds that rate as long as
// results are taken; the ray slab divisions run as four pipelined restoring
// dividers producing one quotient bit per stage. A three-stage front end
// classifies each query and runs the box and circle tests, then parks it in
// a four-entry queue; the back end drains the queue, divides, combines the
// slabs and holds the result in an output register, so a stalled result does
// not stop new query transfers until the queue fills. Write the registers
// only while no query is in flight.
module box_collider_queries_unit #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         query_valid,
  output logic                         query_stall,
  input  bcq_pkg::query_t              query,
  output logic                         result_valid,
  input  logic                         result_stall,
  output bcq_pkg::result_t             result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bcq_pkg::ADDR_W-1:0]   paddr,
  input  logic [bcq_pkg::DATA_W-1:0]   pwdata,
  output logic [bcq_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import bcq_pkg::*;

  logic signed [COORD_W-1:0] box_pos_x, box_pos_y;
  logic [DIM_W-1:0]          box_width, box_height;
  logic                      cfg_write;
  logic [1:0]                cfg_index;

  box_geom_t    geom;
  front_item_t  front_item, fifo_head;
  fifo_status_t fifo_st;
  logic         fifo_push, fifo_pop;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = paddr[3:2];

  // Config registers; write on the access phase of an APB transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      box_pos_x  <= '0;
      box_pos_y  <= '0;
      box_width  <= '0;
      box_height <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_POS_X:  box_pos_x  <= pwdata;
        REG_POS_Y:  box_pos_y  <= pwdata;
        REG_WIDTH:  box_width  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: box_height <= pwdata[DIM_W-1:0];
        default:    box_pos_x  <= box_pos_x;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_POS_X:  prdata = box_pos_x;
      REG_POS_Y:  prdata = box_pos_y;
      REG_WIDTH:  prdata = {1'b0, box_width};
      REG_HEIGHT: prdata = {1'b0, box_height};
      default:    prdata = '0;
    endcase
  end

  // Precompute the box corners and the doubled-unit slab bounds (box
  // centered on its position for the ray). They are registered, so they settle
  // in the cycle after a register write; a query already in flight may see old values.
  always_ff @(posedge clk) begin
    geom.pos_x <= box_pos_x;
    geom.pos_y <= box_pos_y;
    geom.br_x  <= {box_pos_x[COORD_W-1], box_pos_x} + {2'b00, box_width};
    geom.br_y  <= {box_pos_y[COORD_W-1], box_pos_y} + {2'b00, box_height};
    geom.lo2_x <= {box_pos_x[COORD_W-1], box_pos_x[COORD_W-1], box_pos_x, 1'b0}
                - {4'b0000, box_width};
    geom.hi2_x <= {box_pos_x[COORD_W-1], box_pos_x[COORD_W-1], box_pos_x, 1'b0}
                + {4'b0000, box_width};
    geom.lo2_y <= {box_pos_y[COORD_W-1], box_pos_y[COORD_W-1], box_pos_y, 1'b0}
                - {4'b0000, box_height};
    geom.hi2_y <= {box_pos_y[COORD_W-1], box_pos_y[COORD_W-1], box_pos_y, 1'b0}
                + {4'b0000, box_height};
  end

  // Front end: hold query transfers only when its last stage cannot enter the queue.
  bcq_front u_front (
    .clk         (clk),
    .rst         (rst),
    .query_valid (query_valid),
    .query_stall (query_stall),
    .query       (query),
    .geom        (geom),
    .fifo_full   (fifo_st.full),
    .push        (fifo_push),
    .item        (front_item)
  );

  bcq_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (fifo_push),
    .din    (front_item),
    .pop    (fifo_pop),
    .dout   (fifo_head),
    .status (fifo_st)
  );

  // Back end: advance whenever the output register is free or being taken.
  bcq_back #(.FRAC_BITS(COORD_FRAC_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .fifo_item    (fifo_head),
    .fifo_empty   (fifo_st.empty),
    .pop          (fifo_pop),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fifo_push |-> !fifo_st.full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    fifo_pop |-> !fifo_st.empty)
    else $error("queue pop while empty");

  a_miss_no_dist: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.hit |-> result.hit_distance == '0)
    else $error("distance reported on a miss");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule
